// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // fixed payload widths
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // default number of cells
    localparam int DEPTH_DEF = 16;

    typedef logic signed [WORD_W-1:0] t_word;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/deq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  deq_pkg::t_cell_ctrl i_ctrl,
    input  deq_pkg::t_word      i_left_word,
    input  wire                 i_left_valid,
    input  deq_pkg::t_word      i_right_word,
    input  wire                 i_right_valid,
    input  deq_pkg::t_word      i_push_word,
    output deq_pkg::t_word      o_word,
    output logic                o_valid,
    output deq_pkg::t_word      o_tap
);

    deq_pkg::t_word r_word, n_word;
    logic           r_valid, n_valid;
    logic           w_is_rear;

    // this cell holds the rear word when its right neighbor is empty
    assign w_is_rear = r_valid & ~i_right_valid;

    // next contents: shift toward the rear, fill the first free cell,
    // shift toward the front, or drop the rear word
    always_comb begin
        n_word  = r_word;
        n_valid = r_valid;
        if (i_ctrl.push_front) begin
            n_word  = i_left_word;
            n_valid = i_left_valid;
        end else if (i_ctrl.push_rear) begin
            if (i_left_valid && !r_valid) begin
                n_word  = i_push_word;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.pop_front) begin
            n_word  = i_right_word;
            n_valid = i_right_valid;
        end else if (i_ctrl.pop_rear) begin
            if (w_is_rear) begin
                n_valid = 1'b0;
            end
        end
    end

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_valid = r_valid;
    assign o_tap   = w_is_rear ? r_word : '0;

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// input    in         i_valid / o_ready    i_mode, i_data_in
// result   out        o_valid / i_ready    o_data_out, o_status, o_fill_level
//
// one item per cycle: the cells shift, fill or drop at the edge that takes the item,
// and the result is captured in the output slot at that same edge, offered next cycle.
// the front word is read from the first cell, the rear word from an or-tree
// over the cells that marks the last occupied one.
// reset (synchronous, active low) empties every cell; stored words are not cleared.
// a new item is taken while the output slot is empty or is being emptied.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [deq_pkg::MODE_W-1:0]         i_mode,
    input  wire  signed [deq_pkg::WORD_W-1:0]  i_data_in,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [deq_pkg::WORD_W-1:0]  o_data_out,
    output logic [deq_pkg::STATUS_W-1:0]       o_status,
    output logic [$clog2(DEPTH+1)-1:0]         o_fill_level
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    deq_pkg::t_word       w_word  [DEPTH];
    deq_pkg::t_word       w_tap   [DEPTH];
    logic [DEPTH-1:0]     w_valid;
    deq_pkg::t_cell_ctrl  w_ctrl;
    deq_pkg::t_word       w_rear;
    deq_pkg::t_word       w_result;
    deq_pkg::t_status     w_status;
    logic                 w_take;
    logic                 w_empty;
    logic                 w_full;
    deq_pkg::t_mode       w_mode;

    logic                 r_out_valid;
    deq_pkg::t_word       r_data_out;
    deq_pkg::t_status     r_status;
    logic [FILL_W-1:0]    r_fill_out;
    logic [FILL_W-1:0]    r_fill, n_fill;

    assign w_mode  = deq_pkg::t_mode'(i_mode);
    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign w_empty = !w_valid[0];
    assign w_full  = w_valid[DEPTH-1];

    // command decode
    always_comb begin
        w_ctrl   = '0;
        w_result = '0;
        w_status = deq_pkg::ST_OK;
        n_fill   = r_fill;
        if (w_take) begin
            case (w_mode)
                deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
                    if (w_full) begin
                        w_status = deq_pkg::ST_FULL;
                    end else begin
                        w_ctrl.push_front = (w_mode == deq_pkg::MODE_PUSH_FRONT);
                        w_ctrl.push_rear  = (w_mode == deq_pkg::MODE_PUSH_REAR);
                        n_fill = r_fill + FILL_W'(1);
                    end
                end
                deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
                    if (w_empty) begin
                        w_result = '1;
                        w_status = deq_pkg::ST_EMPTY;
                    end else begin
                        w_ctrl.pop_front = (w_mode == deq_pkg::MODE_POP_FRONT);
                        w_ctrl.pop_rear  = (w_mode == deq_pkg::MODE_POP_REAR);
                        w_result = (w_mode == deq_pkg::MODE_POP_FRONT) ? w_word[0] : w_rear;
                        n_fill = r_fill - FILL_W'(1);
                    end
                end
                default: begin
                    w_status = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    // rear word: only the last occupied cell drives its tap
    always_comb begin
        w_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear = w_rear | w_tap[i];
        end
    end

    // chain of cells, cell 0 is the front
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_pkg::t_word w_lw;
        deq_pkg::t_word w_rw;
        logic           w_lv;
        logic           w_rv;

        if (g == 0) begin : g_first
            assign w_lw = i_data_in;
            assign w_lv = 1'b1;
        end else begin : g_mid_l
            assign w_lw = w_word[g-1];
            assign w_lv = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rw = '0;
            assign w_rv = 1'b0;
        end else begin : g_mid_r
            assign w_rw = w_word[g+1];
            assign w_rv = w_valid[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_word   (w_lw),
            .i_left_valid  (w_lv),
            .i_right_word  (w_rw),
            .i_right_valid (w_rv),
            .i_push_word   (i_data_in),
            .o_word        (w_word[g]),
            .o_valid       (w_valid[g]),
            .o_tap         (w_tap[g])
        );
    end

    // fill count and output slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data_out <= w_result;
            r_status   <= w_status;
            r_fill_out <= n_fill;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_data_out;
    assign o_status     = r_status;
    assign o_fill_level = r_fill_out;

    // occupied cells form a contiguous run from the front
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("gap in occupied cells");

    // fill count agrees with the occupied cells
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("fill count out of step with cells");

    // an empty pop reports all ones and an empty queue
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::ST_EMPTY) |->
            (o_data_out == '1 && o_fill_level == '0))
        else $error("bad empty pop result");

    // a refused push leaves the queue full
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::ST_FULL) |->
            (o_data_out == '0 && o_fill_level == FILL_W'(DEPTH)))
        else $error("bad full push result");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import deq_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int FILL_W    = $clog2(DEPTH + 1);
    localparam int RAND_ITEMS = 1300;
    localparam int CYCLE_LIMIT = 200000;

    // predicted deque contents and the results still owed by the block
    class deque_scoreboard;
        typedef struct {
            t_word             word;
            t_status           status;
            logic [FILL_W-1:0] fill;
        } t_deq_result;

        t_word        ring [DEPTH];
        int unsigned  head;
        int unsigned  count;
        t_deq_result  owed [$];
        int unsigned  errors;
        int unsigned  items;
        int unsigned  results;
        int unsigned  empty_pops;
        int unsigned  full_pushes;
        int unsigned  peak_fill;

        function new();
            head        = 0;
            count       = 0;
            errors      = 0;
            items       = 0;
            results     = 0;
            empty_pops  = 0;
            full_pushes = 0;
            peak_fill   = 0;
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pending();
            return owed.size();
        endfunction

        // apply one accepted operation to the predicted deque
        function void note_item(input t_mode mode, input t_word data);
            t_deq_result r;
            int unsigned slot;
            r.word   = '0;
            r.status = ST_OK;
            items++;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                        full_pushes++;
                    end else begin
                        if (mode == MODE_PUSH_FRONT) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            slot = head;
                        end else begin
                            slot = (head + count) % DEPTH;
                        end
                        ring[slot] = data;
                        count++;
                    end
                end
                default: begin
                    if (count == 0) begin
                        r.word   = '1;
                        r.status = ST_EMPTY;
                        empty_pops++;
                    end else begin
                        if (mode == MODE_POP_FRONT) begin
                            slot = head;
                            head = (head + 1) % DEPTH;
                        end else begin
                            slot = (head + count - 1) % DEPTH;
                        end
                        r.word = ring[slot];
                        count--;
                    end
                end
            endcase
            if (count > peak_fill) peak_fill = count;
            r.fill = count[FILL_W-1:0];
            owed.push_back(r);
        endfunction

        // compare one result item with the oldest owed one
        task check_result(input t_word word, input logic [STATUS_W-1:0] status,
                          input logic [FILL_W-1:0] fill);
            t_deq_result r;
            results++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result word=%0d status=%0d fill=%0d",
                                 word, status, fill));
            end else begin
                r = owed.pop_front();
                if (word !== r.word)
                    report($sformatf("result %0d word %0d, predicted %0d",
                                     results, word, r.word));
                if (status !== r.status)
                    report($sformatf("result %0d status %0d, predicted %0d",
                                     results, status, r.status));
                if (fill !== r.fill)
                    report($sformatf("result %0d fill %0d, predicted %0d",
                                     results, fill, r.fill));
            end
        endtask
    endclass

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  tx_valid = 1'b0;
    logic                  o_ready;
    t_mode                 tx_mode = MODE_PUSH_FRONT;
    t_word                 tx_data = '0;
    logic                  o_valid;
    logic                  rx_ready = 1'b0;
    t_word                 o_data_out;
    logic [STATUS_W-1:0]   o_status;
    logic [FILL_W-1:0]     o_fill_level;

    deque_scoreboard       sb;
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           cycles = 0;

    double_ended_queue #(.DEPTH(DEPTH)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (tx_valid),
        .o_ready      (o_ready),
        .i_mode       (tx_mode),
        .i_data_in    (tx_data),
        .o_valid      (o_valid),
        .i_ready      (rx_ready),
        .o_data_out   (o_data_out),
        .o_status     (o_status),
        .o_fill_level (o_fill_level)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL double_ended_queue");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        rx_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && rx_ready)
            sb.check_result(o_data_out, o_status, o_fill_level);
    end

    // drive one item; entered and left at a falling edge
    task send_item(input t_mode mode, input t_word data);
        while ($urandom_range(99) < send_idle_pct) begin
            tx_valid <= 1'b0;
            tx_mode  <= t_mode'($urandom_range(3));
            tx_data  <= $urandom;
            @(negedge i_clk);
        end
        tx_valid <= 1'b1;
        tx_mode  <= mode;
        tx_data  <= data;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(mode, data);
        @(negedge i_clk);
    endtask

    function t_word pick_word();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // edge cases: empty pops, last word out of either end, full at both ends
    task run_directed();
        send_item(MODE_POP_FRONT, 32'sh7fff_ffff);
        send_item(MODE_POP_REAR, 32'sh8000_0000);
        send_item(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        send_item(MODE_POP_REAR, 32'sd0);
        send_item(MODE_PUSH_REAR, 32'sh8000_0000);
        send_item(MODE_POP_FRONT, 32'sd0);
        for (int i = 0; i < DEPTH; i++) begin
            send_item((i % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                      (i % 2) ? (32'sh8000_0000 | i) : (32'sh7fff_fff0 | i));
        end
        send_item(MODE_PUSH_FRONT, -32'sd1);
        send_item(MODE_PUSH_REAR, 32'sd0);
        send_item(MODE_POP_FRONT, 32'sd0);
        send_item(MODE_POP_REAR, 32'sd0);
    endtask

    // runs of mostly pushes, mostly pops or a mix, so full and empty recur
    task run_random(input int unsigned n_items);
        int unsigned push_pct;
        int unsigned run_left;
        t_mode       mode;
        push_pct = 50;
        run_left = 0;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
                run_left = $urandom_range(40, 5);
            end
            run_left--;
            if ($urandom_range(99) < push_pct)
                mode = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else
                mode = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
            send_item(mode, pick_word());
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        // handshake phases: free flowing, sparse input, slow output, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            run_random(RAND_ITEMS / 4);
        end

        tx_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("ran %0d items and checked %0d results over four handshake phases",
                 sb.items, sb.results);
        $display("empty pops %0d, pushes on full %0d, peak fill %0d, mismatches %0d",
                 sb.empty_pops, sb.full_pushes, sb.peak_fill, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS double_ended_queue");
        else
            $display("FAIL double_ended_queue");
        $finish;
    end

endmodule

// File: double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
tb/tb_top.sv
